[hw/rtl/vgrt_pkg.sv]
// Package with the sequencer states, field offsets and fixed widths of the voxel ray caster.
package vgrt_pkg;

   // Command codes carried on the request tuser bit.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // Request tdata field offsets, lowest bit first.
   localparam int VX_LSB = 0;
   localparam int VY_LSB = 5;
   localparam int VZ_LSB = 10;
   localparam int SOLID_BIT = 15;
   localparam int OX_LSB = 16;
   localparam int OY_LSB = 35;
   localparam int OZ_LSB = 54;
   localparam int DX_LSB = 73;
   localparam int DY_LSB = 88;
   localparam int DZ_LSB = 103;
   localparam int MD_LSB = 118;
   localparam int REQ_W = 144;
   localparam int RSP_W = 96;

   // Iteration counts of the shared subtract unit.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 46;

   // Largest normalized direction magnitude (1.0 in Q1.14).
   localparam logic [14:0] DMAG_MAX = 15'd16384;
   localparam logic [18:0] POS_MAX = 19'h3FFFF;
   localparam logic [18:0] POS_MIN = 19'h40000;

   typedef enum logic [14:0] {
      S_CLEAR    = 15'b000000000000001,
      S_IDLE     = 15'b000000000000010,
      S_WR_RD    = 15'b000000000000100,
      S_WR_WB    = 15'b000000000001000,
      S_LEN_MUL  = 15'b000000000010000,
      S_LEN_ACC  = 15'b000000000100000,
      S_SQRT     = 15'b000000001000000,
      S_DIV_LOAD = 15'b000000010000000,
      S_DIV_RUN  = 15'b000000100000000,
      S_DIV_DONE = 15'b000001000000000,
      S_WALK_RD  = 15'b000010000000000,
      S_WALK_CHK = 15'b000100000000000,
      S_HIT_MUL  = 15'b001000000000000,
      S_HIT_ADD  = 15'b010000000000000,
      S_OUT      = 15'b100000000000000
   } state_type;

   // Division phases for one axis.
   typedef enum logic [1:0] {
      PH_DMAG   = 2'd0,
      PH_TDELTA = 2'd1,
      PH_TMAX   = 2'd2
   } phase_type;

endpackage

[hw/rtl/voxel_grid_ray_traversal.sv]
// Voxel occupancy grid with an iterative fixed-point ray caster.
// After reset the block clears its occupancy memory one row per cycle, all
// 2^(2*GRID_BITS) rows (1024 at the default), with req_tready low. A write transfer
// reads the row, modifies the voxel bit and writes the row back. A cast transfer runs
// through one shared subtract unit and one shared multiplier: the squared length, the
// square root, then five to nine divisions (an axis whose normalized component rounds
// to zero needs one division instead of three). The walk then reads the occupancy row
// and checks it for each voxel inside the grid, as the memory read is registered, and
// steps straight on for each voxel outside it. A hit then computes the hit point, a
// multiply and an add per axis, and the output state loads the result.
// A finished result waits in the response register while the next request is taken.
module voxel_grid_ray_traversal #(
   parameter int GRID_BITS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // tdata from bit 0: voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y, origin_z,
   // dir_x, dir_y, dir_z, max_range, zero fill.
   input  logic [vgrt_pkg::REQ_W-1:0]  req_tdata,
   // tuser: command.
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // tdata from bit 0: hit_voxel_x, hit_voxel_y, hit_voxel_z, hit_distance, hit_face,
   // hit_pos_x, hit_pos_y, hit_pos_z, zero fill.
   output logic [vgrt_pkg::RSP_W-1:0]  rsp_tdata,
   // tuser: hit_valid.
   output logic                        rsp_tuser
);

   localparam int SIDE = 1 << GRID_BITS;
   localparam int ROW_AW = 2 * GRID_BITS;
   localparam int ROWS = 1 << ROW_AW;

   vgrt_pkg::state_type state_ff, state_in;
   vgrt_pkg::phase_type phase_ff, phase_in;

   logic [ROW_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [vgrt_pkg::REQ_W-1:0] in_ff, in_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] ax_ff, ax_in;
   logic [31:0] len2_ff, len2_in;
   logic [42:0] prod_ff, prod_in;
   logic [63:0] sq_v_ff, sq_v_in, sq_r_ff, sq_r_in;
   logic [31:0] lenq_ff, lenq_in;
   logic [31:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [45:0] dvd_ff, dvd_in;
   logic [14:0] dmag_ff [3];
   logic [14:0] dmag_in [3];
   logic [26:0] tdel_ff [3];
   logic [26:0] tdel_in [3];
   logic [27:0] tmax_ff [3];
   logic [27:0] tmax_in [3];
   logic [2:0] act_ff, act_in, spos_ff, spos_in;
   logic signed [11:0] pos_ff [3];
   logic signed [11:0] pos_in [3];
   logic [1:0] axis_ff, axis_in;
   logic [27:0] dist_ff, dist_in;
   logic [18:0] hpos_ff [3];
   logic [18:0] hpos_in [3];
   logic hit_ff, hit_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [vgrt_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   // Occupancy memory, one row of voxels along x per entry.
   logic [SIDE-1:0] mem [ROWS];
   logic [SIDE-1:0] rd_data_ff;
   logic mem_we;
   logic [ROW_AW-1:0] mem_waddr, mem_raddr;
   logic [SIDE-1:0] mem_wdata;

   // Field views of the latched request.
   logic [4:0] f_vx, f_vy, f_vz;
   logic f_solid;
   logic signed [18:0] f_org [3];
   logic signed [14:0] f_dir [3];
   logic [19:0] f_maxd;
   logic [14:0] dir_mag [3];

   assign f_vx = in_ff[vgrt_pkg::VX_LSB +: 5];
   assign f_vy = in_ff[vgrt_pkg::VY_LSB +: 5];
   assign f_vz = in_ff[vgrt_pkg::VZ_LSB +: 5];
   assign f_solid = in_ff[vgrt_pkg::SOLID_BIT];
   assign f_org[0] = in_ff[vgrt_pkg::OX_LSB +: 19];
   assign f_org[1] = in_ff[vgrt_pkg::OY_LSB +: 19];
   assign f_org[2] = in_ff[vgrt_pkg::OZ_LSB +: 19];
   assign f_dir[0] = in_ff[vgrt_pkg::DX_LSB +: 15];
   assign f_dir[1] = in_ff[vgrt_pkg::DY_LSB +: 15];
   assign f_dir[2] = in_ff[vgrt_pkg::DZ_LSB +: 15];
   assign f_maxd = in_ff[vgrt_pkg::MD_LSB +: 20];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dir_mag[a] = f_dir[a][14] ? 15'(-f_dir[a]) : 15'(f_dir[a]);
      end
   end

   // Shared subtract unit, used by the square root and by the divider.
   logic [63:0] sub_a, sub_b, sq_bit;
   logic [64:0] sub_d;
   logic sub_ok;
   logic [32:0] div_sh;

   assign sq_bit = 64'(1) << (6'd62 - {cnt_ff[4:0], 1'b0});
   assign div_sh = {rem_ff, dvd_ff[45]};

   always_comb begin
      if (state_ff == vgrt_pkg::S_SQRT) begin
         sub_a = sq_v_ff;
         sub_b = sq_r_ff + sq_bit;
      end else begin
         sub_a = 64'(div_sh);
         sub_b = 64'(dvs_ff);
      end
   end
   assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok = !sub_d[64];

   // Shared multiplier.
   logic [27:0] mul_a;
   logic [14:0] mul_b;
   always_comb begin
      if (state_ff == vgrt_pkg::S_HIT_MUL) begin
         mul_a = dist_ff;
         mul_b = dmag_ff[ax_ff];
      end else begin
         mul_a = 28'(dir_mag[ax_ff]);
         mul_b = dir_mag[ax_ff];
      end
   end

   // Walk step: pick the axis with the smallest finite tMax, ties to the later axis.
   logic lt01, lt02, lt12;
   logic [1:0] sel;
   logic in_grid;
   logic [SIDE-1:0] wb_row;
   logic [GRID_BITS-1:0] wx;
   logic wr_ok;

   assign lt01 = act_ff[0] && (!act_ff[1] || tmax_ff[0] < tmax_ff[1]);
   assign lt02 = act_ff[0] && (!act_ff[2] || tmax_ff[0] < tmax_ff[2]);
   assign lt12 = act_ff[1] && (!act_ff[2] || tmax_ff[1] < tmax_ff[2]);
   assign sel = (lt01 && lt02) ? 2'd0 : (lt12 ? 2'd1 : 2'd2);

   assign in_grid = (pos_ff[0] >= 0) && (pos_ff[0] < $signed(12'(SIDE))) &&
                    (pos_ff[1] >= 0) && (pos_ff[1] < $signed(12'(SIDE))) &&
                    (pos_ff[2] >= 0) && (pos_ff[2] < $signed(12'(SIDE)));

   assign wx = GRID_BITS'(f_vx);
   assign wr_ok = ((6'(f_vx) >> GRID_BITS) == 6'd0) && ((6'(f_vy) >> GRID_BITS) == 6'd0) &&
                  ((6'(f_vz) >> GRID_BITS) == 6'd0);

   always_comb begin
      wb_row = rd_data_ff;
      wb_row[wx] = f_solid;
   end

   // Hit point arithmetic for the axis in turn.
   logic [28:0] off;
   logic signed [29:0] hp;
   assign off = 29'((prod_ff + 43'd8192) >> 14);
   assign hp = f_dir[ax_ff][14] ? (30'(f_org[ax_ff]) - $signed({1'b0, off}))
                                : (30'(f_org[ax_ff]) + $signed({1'b0, off}));

   assign req_tready = (state_ff == vgrt_pkg::S_IDLE);

   // Sequencer and datapath next values.
   always_comb begin
      logic [45:0] q;
      logic [11:0] f;
      logic [12:0] b;
      state_in = state_ff;
      phase_in = phase_ff;
      clr_cnt_in = clr_cnt_ff;
      in_in = in_ff;
      cnt_in = cnt_ff;
      ax_in = ax_ff;
      len2_in = len2_ff;
      prod_in = prod_ff;
      sq_v_in = sq_v_ff;
      sq_r_in = sq_r_ff;
      lenq_in = lenq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      dvd_in = dvd_ff;
      dmag_in = dmag_ff;
      tdel_in = tdel_ff;
      tmax_in = tmax_ff;
      act_in = act_ff;
      spos_in = spos_ff;
      pos_in = pos_ff;
      axis_in = axis_ff;
      dist_in = dist_ff;
      hpos_in = hpos_ff;
      hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mem_we = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      mem_raddr = {pos_ff[2][GRID_BITS-1:0], pos_ff[1][GRID_BITS-1:0]};
      q = dvd_ff;
      f = f_org[ax_ff][11:0];
      b = spos_ff[ax_ff] ? (13'd4096 - 13'(f)) : 13'(f);

      case (state_ff)
         vgrt_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ROW_AW'(ROWS - 1)) state_in = vgrt_pkg::S_IDLE;
         end
         vgrt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               in_in = req_tdata;
               if (req_tuser == vgrt_pkg::CMD_WRITE) begin
                  state_in = vgrt_pkg::S_WR_RD;
               end else begin
                  state_in = vgrt_pkg::S_LEN_MUL;
                  ax_in = 2'd0;
                  len2_in = '0;
               end
            end
         end
         vgrt_pkg::S_WR_RD: begin
            mem_raddr = {GRID_BITS'(f_vz), GRID_BITS'(f_vy)};
            state_in = vgrt_pkg::S_WR_WB;
         end
         vgrt_pkg::S_WR_WB: begin
            mem_we = wr_ok;
            mem_waddr = {GRID_BITS'(f_vz), GRID_BITS'(f_vy)};
            mem_wdata = wb_row;
            state_in = vgrt_pkg::S_IDLE;
         end
         vgrt_pkg::S_LEN_MUL: begin
            prod_in = mul_a * mul_b;
            pos_in[ax_ff] = 12'(f_org[ax_ff] >>> 12);
            state_in = vgrt_pkg::S_LEN_ACC;
         end
         vgrt_pkg::S_LEN_ACC: begin
            len2_in = len2_ff + 32'(prod_ff);
            if (ax_ff == 2'd2) begin
               hit_in = 1'b0;
               if (len2_ff + 32'(prod_ff) == 32'd0) begin
                  state_in = vgrt_pkg::S_OUT;
               end else begin
                  sq_v_in = {len2_ff + 32'(prod_ff), 32'd0};
                  sq_r_in = '0;
                  cnt_in = '0;
                  state_in = vgrt_pkg::S_SQRT;
               end
            end else begin
               ax_in = ax_ff + 1'b1;
               state_in = vgrt_pkg::S_LEN_MUL;
            end
         end
         vgrt_pkg::S_SQRT: begin
            // One root digit per cycle.
            if (sub_ok) begin
               sq_v_in = sub_d[63:0];
               sq_r_in = (sq_r_ff >> 1) + sq_bit;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(vgrt_pkg::SQRT_STEPS - 1)) begin
               state_in = vgrt_pkg::S_DIV_LOAD;
               ax_in = 2'd0;
               phase_in = vgrt_pkg::PH_DMAG;
            end
         end
         vgrt_pkg::S_DIV_LOAD: begin
            if (cnt_ff == 6'(vgrt_pkg::SQRT_STEPS)) lenq_in = sq_r_ff[31:0];
            rem_in = '0;
            cnt_in = '0;
            case (phase_ff)
               vgrt_pkg::PH_DMAG: begin
                  dvd_in = {1'b0, dir_mag[ax_ff], 30'd0} + 46'(lenq_in >> 1);
                  dvs_in = lenq_in;
               end
               vgrt_pkg::PH_TDELTA: begin
                  dvd_in = 46'(1 << 26) + 46'(dmag_ff[ax_ff] >> 1);
                  dvs_in = 32'(dmag_ff[ax_ff]);
               end
               default: begin
                  dvd_in = {19'd0, b, 14'd0} + 46'(dmag_ff[ax_ff] >> 1);
                  dvs_in = 32'(dmag_ff[ax_ff]);
               end
            endcase
            state_in = vgrt_pkg::S_DIV_RUN;
         end
         vgrt_pkg::S_DIV_RUN: begin
            // One quotient bit per cycle.
            rem_in = sub_ok ? sub_d[31:0] : div_sh[31:0];
            dvd_in = {dvd_ff[44:0], sub_ok};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(vgrt_pkg::DIV_STEPS - 1)) state_in = vgrt_pkg::S_DIV_DONE;
         end
         vgrt_pkg::S_DIV_DONE: begin
            state_in = vgrt_pkg::S_DIV_LOAD;
            case (phase_ff)
               vgrt_pkg::PH_DMAG: begin
                  dmag_in[ax_ff] = (q > 46'(vgrt_pkg::DMAG_MAX)) ? vgrt_pkg::DMAG_MAX : q[14:0];
                  act_in[ax_ff] = (q != 46'd0);
                  spos_in[ax_ff] = (q != 46'd0) && !f_dir[ax_ff][14];
                  phase_in = vgrt_pkg::PH_TDELTA;
                  if (q == 46'd0) phase_in = vgrt_pkg::PH_TMAX;
               end
               vgrt_pkg::PH_TDELTA: begin
                  tdel_in[ax_ff] = q[26:0];
                  phase_in = vgrt_pkg::PH_TMAX;
               end
               default: begin
                  tmax_in[ax_ff] = q[27:0];
                  phase_in = vgrt_pkg::PH_DMAG;
               end
            endcase
            if ((phase_ff == vgrt_pkg::PH_TMAX) || (phase_ff == vgrt_pkg::PH_DMAG && q == 46'd0))
            begin
               phase_in = vgrt_pkg::PH_DMAG;
               if (ax_ff == 2'd2) begin
                  state_in = vgrt_pkg::S_WALK_RD;
                  dist_in = '0;
                  axis_in = 2'd0;
               end else begin
                  ax_in = ax_ff + 1'b1;
               end
            end
         end
         vgrt_pkg::S_WALK_RD: begin
            if (dist_ff >= 28'(f_maxd)) begin
               hit_in = 1'b0;
               state_in = vgrt_pkg::S_OUT;
            end else if (in_grid) begin
               state_in = vgrt_pkg::S_WALK_CHK;
            end else begin
               axis_in = sel;
               dist_in = tmax_ff[sel];
               pos_in[sel] = spos_ff[sel] ? pos_ff[sel] + 12'sd1 : pos_ff[sel] - 12'sd1;
               tmax_in[sel] = tmax_ff[sel] + 28'(tdel_ff[sel]);
            end
         end
         vgrt_pkg::S_WALK_CHK: begin
            if (rd_data_ff[pos_ff[0][GRID_BITS-1:0]]) begin
               hit_in = 1'b1;
               ax_in = 2'd0;
               state_in = vgrt_pkg::S_HIT_MUL;
            end else begin
               axis_in = sel;
               dist_in = tmax_ff[sel];
               pos_in[sel] = spos_ff[sel] ? pos_ff[sel] + 12'sd1 : pos_ff[sel] - 12'sd1;
               tmax_in[sel] = tmax_ff[sel] + 28'(tdel_ff[sel]);
               state_in = vgrt_pkg::S_WALK_RD;
            end
         end
         vgrt_pkg::S_HIT_MUL: begin
            prod_in = mul_a * mul_b;
            state_in = vgrt_pkg::S_HIT_ADD;
         end
         vgrt_pkg::S_HIT_ADD: begin
            // Saturate the hit point to the signed 19-bit range.
            if (hp > 30'sd262143) hpos_in[ax_ff] = vgrt_pkg::POS_MAX;
            else if (hp < -30'sd262144) hpos_in[ax_ff] = vgrt_pkg::POS_MIN;
            else hpos_in[ax_ff] = hp[18:0];
            if (ax_ff == 2'd2) begin
               state_in = vgrt_pkg::S_OUT;
            end else begin
               ax_in = ax_ff + 1'b1;
               state_in = vgrt_pkg::S_HIT_MUL;
            end
         end
         vgrt_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = hit_ff;
               rsp_data_in = '0;
               if (hit_ff) begin
                  rsp_data_in = {1'b0, hpos_ff[2], hpos_ff[1], hpos_ff[0],
                                 {axis_ff, 1'b0} + {2'd0, !spos_ff[axis_ff]},
                                 dist_ff[19:0], pos_ff[2][4:0], pos_ff[1][4:0],
                                 pos_ff[0][4:0]};
               end
               state_in = vgrt_pkg::S_IDLE;
            end
         end
         default: state_in = vgrt_pkg::S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vgrt_pkg::S_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      in_ff <= in_in;
      cnt_ff <= cnt_in;
      ax_ff <= ax_in;
      len2_ff <= len2_in;
      prod_ff <= prod_in;
      sq_v_ff <= sq_v_in;
      sq_r_ff <= sq_r_in;
      lenq_ff <= lenq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      dmag_ff <= dmag_in;
      tdel_ff <= tdel_in;
      tmax_ff <= tmax_in;
      act_ff <= act_in;
      spos_ff <= spos_in;
      pos_ff <= pos_in;
      axis_ff <= axis_in;
      dist_ff <= dist_in;
      hpos_ff <= hpos_in;
      hit_ff <= hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Occupancy memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // A transfer on the request side always starts work.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != vgrt_pkg::S_IDLE)
      else $error("request transfer left the sequencer idle");

   // No request is taken during the clearing pass.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == vgrt_pkg::S_CLEAR |-> !req_tready)
      else $error("request ready during clearing pass");

   // A miss carries an all-zero payload.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss result with nonzero payload");

   // A hit reports a legal face code.
   a_face_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[37:35] <= 3'd5)
      else $error("hit result with illegal face code");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the voxel grid ray caster: directed and random traffic.
module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 2000;

   // One hit record as carried on the response channel.
   typedef struct packed {
      logic        hit;
      logic [4:0]  vx, vy, vz;
      logic [19:0] hdist;
      logic [2:0]  face;
      logic [18:0] px, py, pz;
   } hit_rec_type;

   // One request as sent on the request channel.
   typedef struct {
      logic         cmd;
      logic [4:0]   vx, vy, vz;
      logic         solid;
      logic [18:0]  ox, oy, oz;
      logic [14:0]  dx, dy, dz;
      logic [19:0]  md;
      bit           has_exp;
      hit_rec_type  exp_rec;
   } ray_req_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [vgrt_pkg::REQ_W-1:0] req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [vgrt_pkg::RSP_W-1:0] rsp_tdata;
   logic                       rsp_tuser;

   bit          grid_model [32768];
   hit_rec_type pending_hits [$];
   ray_req_type ray_table [$];
   bit          failed;
   bit          no_idle;
   int          stall_count;

   voxel_grid_ray_traversal dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit voxel_solid(input longint x, input longint y, input longint z);
      if (x < 0 || x > 31 || y < 0 || y > 31 || z < 0 || z > 31) return 1'b0;
      return grid_model[x + (y << 5) + (z << 10)];
   endfunction

   // Applies a write, or walks a ray through the grid and returns the hit record.
   function automatic hit_rec_type trace_ray(input ray_req_type r);
      hit_rec_type res;
      longint org [3], dir [3], pos [3], stp [3];
      logic [63:0] dm [3], tmx [3], tdl [3];
      logic [63:0] len2, lq, trav, f, b, off;
      longint p;
      int ax, a;
      res = '0;
      if (r.cmd == vgrt_pkg::CMD_WRITE) begin
         grid_model[int'(r.vx) + (int'(r.vy) << 5) + (int'(r.vz) << 10)] = r.solid;
         return res;
      end
      org[0] = $signed(r.ox); org[1] = $signed(r.oy); org[2] = $signed(r.oz);
      dir[0] = $signed(r.dx); dir[1] = $signed(r.dy); dir[2] = $signed(r.dz);
      len2 = 0;
      for (a = 0; a < 3; a++) len2 += mag64(dir[a]) * mag64(dir[a]);
      if (len2 == 0) return res;
      lq = root64(len2 << 32);
      for (a = 0; a < 3; a++) begin
         f = org[a] & 64'hFFF;
         dm[a] = ((mag64(dir[a]) << 30) + lq / 2) / lq;
         if (dm[a] > 16384) dm[a] = 16384;
         pos[a] = (org[a] - longint'(f)) / 4096;
         stp[a] = (dm[a] != 0 && dir[a] > 0) ? 1 : -1;
         if (dm[a] != 0) begin
            b = (stp[a] > 0) ? 4096 - f : f;
            tdl[a] = ((64'd1 << 26) + dm[a] / 2) / dm[a];
            tmx[a] = ((b << 14) + dm[a] / 2) / dm[a];
         end else begin
            tdl[a] = 64'd1 << 62;
            tmx[a] = 64'd1 << 62;
         end
      end
      trav = 0;
      ax = 0;
      while (trav < r.md) begin
         if (voxel_solid(pos[0], pos[1], pos[2])) begin
            res.hit = 1'b1;
            res.vx = pos[0][4:0]; res.vy = pos[1][4:0]; res.vz = pos[2][4:0];
            res.hdist = trav[19:0];
            res.face = 3'(2 * ax + (stp[ax] > 0 ? 0 : 1));
            for (a = 0; a < 3; a++) begin
               off = (dm[a] * trav + 8192) >> 14;
               p = (dir[a] < 0) ? org[a] - longint'(off) : org[a] + longint'(off);
               if (p > 262143) p = 262143;
               if (p < -262144) p = -262144;
               if (a == 0) res.px = p[18:0];
               else if (a == 1) res.py = p[18:0];
               else res.pz = p[18:0];
            end
            return res;
         end
         if (tmx[0] < tmx[1] && tmx[0] < tmx[2]) ax = 0;
         else if (tmx[1] < tmx[2]) ax = 1;
         else ax = 2;
         trav = tmx[ax];
         pos[ax] += stp[ax];
         tmx[ax] += tdl[ax];
      end
      return res;
   endfunction

   function automatic ray_req_type make_write(input int x, y, z, input bit s);
      ray_req_type r;
      r = '{default: '0};
      r.cmd = vgrt_pkg::CMD_WRITE;
      r.vx = 5'(x); r.vy = 5'(y); r.vz = 5'(z); r.solid = s;
      return r;
   endfunction

   function automatic ray_req_type make_cast(input int ox, oy, oz, dx, dy, dz, md);
      ray_req_type r;
      r = '{default: '0};
      r.cmd = vgrt_pkg::CMD_CAST;
      r.ox = 19'(ox); r.oy = 19'(oy); r.oz = 19'(oz);
      r.dx = 15'(dx); r.dy = 15'(dy); r.dz = 15'(dz); r.md = 20'(md);
      return r;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input ray_req_type r);
      ray_table.insert(ray_table.size(), r);
   endfunction

   // Random cast; mostly rays aimed across the grid with short reach.
   function automatic ray_req_type random_cast();
      ray_req_type r;
      if ($urandom_range(0, 9) < 8) begin
         r = make_cast($urandom_range(0, 32 * 4096 - 1), $urandom_range(0, 32 * 4096 - 1),
                       $urandom_range(0, 32 * 4096 - 1),
                       $signed(15'($urandom)), $signed(15'($urandom)),
                       $signed(15'($urandom)), $urandom_range(0, 12 * 4096));
         if ($urandom_range(0, 5) == 0) r.dx = 0;
         if ($urandom_range(0, 5) == 0) r.dy = 0;
      end else begin
         r = make_cast($signed(19'($urandom)), $signed(19'($urandom)),
                       $signed(19'($urandom)), $signed(15'($urandom)),
                       $signed(15'($urandom)), $signed(15'($urandom)),
                       $urandom_range(0, 40 * 4096));
         if ($urandom_range(0, 20) == 0) r.md = 20'hFFFFF;
      end
      return r;
   endfunction

   // Sends one transfer on the request channel and, for a cast, records its expected hit.
   task automatic send_req(input ray_req_type r);
      hit_rec_type pred;
      while (!no_idle && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {6'd0, r.md, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox,
                    r.solid, r.vz, r.vy, r.vx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = trace_ray(r);
      if (r.cmd == vgrt_pkg::CMD_CAST) begin
         if (r.has_exp && r.exp_rec !== pred) begin
            $display("%0t predictor disagrees with table row: expected %h actual %h",
                     $time, r.exp_rec, pred);
            failed = 1'b1;
         end
         pending_hits.insert(pending_hits.size(), r.has_exp ? r.exp_rec : pred);
      end
      @(negedge clock);
   endtask

   // Response side: random back-pressure and field checks.
   always @(negedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      hit_rec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tuser;
         got.vx = rsp_tdata[4:0];
         got.vy = rsp_tdata[9:5];
         got.vz = rsp_tdata[14:10];
         got.hdist = rsp_tdata[34:15];
         got.face = rsp_tdata[37:35];
         got.px = rsp_tdata[56:38];
         got.py = rsp_tdata[75:57];
         got.pz = rsp_tdata[94:76];
         if (pending_hits.size() == 0) begin
            $display("%0t unexpected result transfer: actual %h", $time, got);
            failed = 1'b1;
         end else begin
            want = pending_hits.pop_front();
            if (got.hit !== want.hit || got.vx !== want.vx || got.vy !== want.vy ||
                got.vz !== want.vz || got.hdist !== want.hdist || got.face !== want.face ||
                got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
               $display("%0t hit mismatch: expected %h actual %h", $time, want, got);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer; the clearing pass fits well inside.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("[voxel_grid_ray_traversal] ERROR");
         $finish;
      end
   end

   initial begin
      ray_req_type r;
      int n, wait_cycles;
      hit_rec_type miss;
      miss = '0;
      failed = 1'b0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = vgrt_pkg::CMD_WRITE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: misses on an empty grid, extremes, special cases.
      r = make_cast(0, 0, 0, 16383, 0, 0, 20'hFFFFF); r.has_exp = 1; r.exp_rec = miss;
      add_row(r);
      r = make_cast(4096, 4096, 4096, 0, 0, 0, 8192); r.has_exp = 1; r.exp_rec = miss;
      add_row(r);
      add_row(make_write(5, 0, 0, 1));
      add_row(make_write(31, 31, 31, 1));
      add_row(make_write(0, 0, 0, 1));
      r = make_cast(2048, 2048, 2048, 0, 0, 0, 8192); r.has_exp = 1; r.exp_rec = miss;
      add_row(r);
      r = make_cast(2048, 2048, 2048, 16383, 0, 0, 0); r.has_exp = 1; r.exp_rec = miss;
      add_row(r);
      add_row(make_cast(2048, 2048, 2048, 16383, 0, 0, 40960));
      add_row(make_cast(2048, 2048, 2048, -16384, 0, 0, 40960));
      add_row(make_cast(22528, 2048, 2048, 0, 0, 0, 1));
      add_row(make_cast(30 * 4096 + 7, 30 * 4096, 30 * 4096, 9000, 9000,
                        9000, 20'hFFFFF));
      add_row(make_cast(-4096, 2048, 2048, 16383, 1, 0, 40960));
      add_row(make_cast(262143, 262143, 262143, -16384, -16384, -16384,
                        20'hFFFFF));
      add_row(make_cast(-262144, -262144, -262144, 16383, 16383, 16383,
                        20'hFFFFF));
      add_row(make_cast(2048, 2048, 2048, 16383, 16383, 0, 40960));
      add_row(make_cast(4095, 2048, 2048, 1, 0, 0, 20'hFFFFF));
      add_row(make_write(0, 0, 0, 0));
      add_row(make_cast(2048, 2048, 2048, 0, 0, 0, 8192));
      add_row(make_cast(2048, 2048, 2048, 16383, 0, 0, 40960));
      foreach (ray_table[i]) send_req(ray_table[i]);

      // Random part: fill the grid, then mix writes and casts.
      for (n = 0; n < 750; n++) begin
         no_idle = (n >= 300 && n < 380);
         if (n < 120 || $urandom_range(0, 3) == 0)
            send_req(make_write($urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 31), $urandom_range(0, 3) != 0));
         else
            send_req(random_cast());
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // Drain outstanding hits, then let the block settle.
      wait_cycles = 0;
      while (pending_hits.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_hits.size() != 0) begin
         $display("%0t results missing: expected %0d more, actual 0", $time,
                  pending_hits.size());
         failed = 1'b1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("[voxel_grid_ray_traversal] OK");
      else
         $display("[voxel_grid_ray_traversal] ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/vgrt_pkg.sv
hw/rtl/voxel_grid_ray_traversal.sv
test/tb_top.sv
